/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the log range unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define TLRC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication
`define TLRC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TLRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tlrc_pkg.sv */
// Constants, codes and types of the timestamped log range unit
`timescale 1ns / 1ps

package tlrc_pkg;

   // log geometry
   localparam int LOG_DEPTH = 1024;
   localparam int IDX_W     = $clog2(LOG_DEPTH);
   localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

   // field widths
   localparam int TIME_W   = 64;
   localparam int COST_W   = 32;
   localparam int SUM_W    = 64;
   localparam int STATUS_W = 2;
   localparam int WCOUNT_W = 11;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

   // command codes
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // write request into the log store
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  addr;
      logic [TIME_W-1:0] stamp;
      logic [SUM_W-1:0]  prefix;
   } store_wr_type;

endpackage

/* rtl/core/tlrc_if.sv */
// Request and response channel interfaces of the log range unit
`timescale 1ns / 1ps

interface tlrc_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [tlrc_pkg::TIME_W-1:0] order_time;
   logic [tlrc_pkg::COST_W-1:0] order_cost;
   logic [tlrc_pkg::TIME_W-1:0] start_time;
   logic [tlrc_pkg::TIME_W-1:0] end_time;

   modport source (
      output valid, command, order_time, order_cost, start_time, end_time,
      input  ready
   );
   modport sink (
      input  valid, command, order_time, order_cost, start_time, end_time,
      output ready
   );
endinterface

interface tlrc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tlrc_pkg::STATUS_W-1:0] status;
   logic [tlrc_pkg::WCOUNT_W-1:0] window_count;
   logic [tlrc_pkg::SUM_W-1:0]    window_cost_sum;

   modport source (
      output valid, status, window_count, window_cost_sum,
      input  ready
   );
   modport sink (
      input  valid, status, window_count, window_cost_sum,
      output ready
   );
endinterface

/* rtl/core/tlrc_store.sv */
// Timestamp and prefix-sum memories of the log, one write and one read port
`timescale 1ns / 1ps

module tlrc_store (
   input  logic                          clock,
   input  tlrc_pkg::store_wr_type        wr,
   input  logic [tlrc_pkg::IDX_W-1:0]    rd_addr,
   output logic [tlrc_pkg::TIME_W-1:0]   rd_stamp,
   output logic [tlrc_pkg::SUM_W-1:0]    rd_prefix
);

   logic [tlrc_pkg::TIME_W-1:0] stamp_mem  [tlrc_pkg::LOG_DEPTH];
   logic [tlrc_pkg::SUM_W-1:0]  prefix_mem [tlrc_pkg::LOG_DEPTH];
   logic [tlrc_pkg::TIME_W-1:0] rd_stamp_ff;
   logic [tlrc_pkg::SUM_W-1:0]  rd_prefix_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         stamp_mem[wr.addr]  <= wr.stamp;
         prefix_mem[wr.addr] <= wr.prefix;
      end
   end

   // registered read port, both arrays at one address
   always_ff @(posedge clock) begin
      rd_stamp_ff  <= stamp_mem[rd_addr];
      rd_prefix_ff <= prefix_mem[rd_addr];
   end

   assign rd_stamp  = rd_stamp_ff;
   assign rd_prefix = rd_prefix_ff;

endmodule

/* rtl/core/timestamped_log_range_count_sum_unit.sv */
// Top level of the timestamped log range unit: command sequencer and datapath
//
// Keeps a log of up to LOG_DEPTH (1024) timestamped orders with running prefix
// sums and answers window queries over (start_time, end_time]. A query runs two
// binary searches over the log, interleaved on the single read port of the store
// and sharing one 64-bit comparator. Each search needs up to
// k = ceil(log2(entries + 1)) probes. The store's read port is registered, so
// each search waits for its probe's data before issuing the next, and the two
// searches take turns on the port. The prefix reads follow (FETCH_R, FETCH_L,
// LATCH_L), then DONE loads the result. An append, an empty log or a reversed
// window goes from acceptance straight to DONE. The input is ready again once
// the result is loaded. A finished result waits in the output register while
// the next item is taken; the block stalls only when a new result is due and
// the previous one has still not been taken. No clearing pass is needed after
// reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timestamped_log_range_count_sum_unit (
   input  logic         clock,
   input  logic         reset,
   tlrc_req_if.sink     req_chan,
   tlrc_rsp_if.source   rsp_chan
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SEARCH  = 3'd1;
   localparam logic [2:0] S_FETCH_R = 3'd2;
   localparam logic [2:0] S_FETCH_L = 3'd3;
   localparam logic [2:0] S_LATCH_L = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   localparam int CNT_W = tlrc_pkg::CNT_W;
   localparam int IDX_W = tlrc_pkg::IDX_W;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] entry_count_ff, entry_count_in;
   logic             sel_ff, sel_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [tlrc_pkg::TIME_W-1:0]   last_stamp_ff, last_stamp_in;
   logic [tlrc_pkg::SUM_W-1:0]    last_prefix_ff, last_prefix_in;
   logic [tlrc_pkg::TIME_W-1:0]   key_l_ff, key_l_in, key_r_ff, key_r_in;
   logic [CNT_W-1:0]              lo_l_ff, lo_l_in, hi_l_ff, hi_l_in;
   logic [CNT_W-1:0]              lo_r_ff, lo_r_in, hi_r_ff, hi_r_in;
   logic [CNT_W-1:0]              mid_ff, mid_in;
   logic [tlrc_pkg::SUM_W-1:0]    p_r_ff, p_r_in, p_l_ff, p_l_in;
   logic [tlrc_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [tlrc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [tlrc_pkg::WCOUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [tlrc_pkg::SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;

   // combinational helpers
   logic                        accept, out_free;
   logic                        log_full, log_empty, out_of_order;
   logic [tlrc_pkg::SUM_W-1:0]  new_prefix;
   logic                        sel_active;
   logic [CNT_W-1:0]            sel_lo, sel_hi, mid_cur;
   logic [CNT_W:0]              mid_sum;
   logic [CNT_W-1:0]            lo_r_dec, lo_l_dec;
   logic [tlrc_pkg::TIME_W-1:0] key_pend;
   logic                        hit;
   logic [CNT_W-1:0]            win_count;
   logic [tlrc_pkg::SUM_W-1:0]  win_sum;

   tlrc_pkg::store_wr_type      wr;
   logic [IDX_W-1:0]            rd_addr;
   logic [tlrc_pkg::TIME_W-1:0] rd_stamp;
   logic [tlrc_pkg::SUM_W-1:0]  rd_prefix;

   tlrc_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_addr   (rd_addr),
      .rd_stamp  (rd_stamp),
      .rd_prefix (rd_prefix)
   );

   // handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // append checks and new prefix
   assign log_full     = (entry_count_ff == CNT_W'(tlrc_pkg::LOG_DEPTH));
   assign log_empty    = (entry_count_ff == '0);
   assign out_of_order = !log_empty && (req_chan.order_time < last_stamp_ff);
   assign new_prefix   = (log_empty ? '0 : last_prefix_ff)
                         + tlrc_pkg::SUM_W'(req_chan.order_cost);

   assign wr.we     = accept && (req_chan.command == tlrc_pkg::CMD_APPEND)
                      && !log_full && !out_of_order;
   assign wr.addr   = entry_count_ff[IDX_W-1:0];
   assign wr.stamp  = req_chan.order_time;
   assign wr.prefix = new_prefix;

   // probe address of the search whose turn it is (sel 0: start, 1: end)
   assign sel_lo     = sel_ff ? lo_r_ff : lo_l_ff;
   assign sel_hi     = sel_ff ? hi_r_ff : hi_l_ff;
   assign sel_active = sel_lo < sel_hi;
   assign mid_sum    = {1'b0, sel_lo} + {1'b0, sel_hi};
   assign mid_cur    = mid_sum[CNT_W:1];
   assign lo_r_dec   = lo_r_ff - CNT_W'(1);
   assign lo_l_dec   = lo_l_ff - CNT_W'(1);

   // shared comparator: data returned belongs to the other search
   assign key_pend = sel_ff ? key_l_ff : key_r_ff;
   assign hit      = (rd_stamp <= key_pend);

   // final subtractions
   assign win_count = lo_r_ff - lo_l_ff;
   assign win_sum   = p_r_ff - p_l_ff;

   // read address select
   always_comb begin
      unique case (state_ff)
         S_SEARCH:  rd_addr = mid_cur[IDX_W-1:0];
         S_FETCH_R: rd_addr = lo_r_dec[IDX_W-1:0];
         S_FETCH_L: rd_addr = lo_l_dec[IDX_W-1:0];
         default:   rd_addr = '0;
      endcase
   end

   // sequencer and datapath next values
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      sel_in         = sel_ff;
      pend_in        = pend_ff;
      last_stamp_in  = last_stamp_ff;
      last_prefix_in = last_prefix_ff;
      key_l_in       = key_l_ff;
      key_r_in       = key_r_ff;
      lo_l_in        = lo_l_ff;
      hi_l_in        = hi_l_ff;
      lo_r_in        = lo_r_ff;
      hi_r_in        = hi_r_ff;
      mid_in         = mid_ff;
      p_r_in         = p_r_ff;
      p_l_in         = p_l_ff;
      status_in      = status_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_sum_in     = rsp_sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // zero window unless a search is started below
               lo_l_in   = '0;
               lo_r_in   = '0;
               p_r_in    = '0;
               p_l_in    = '0;
               status_in = tlrc_pkg::ST_OK;
               state_in  = S_DONE;
               if (req_chan.command == tlrc_pkg::CMD_APPEND) begin
                  priority if (log_full) begin
                     status_in = tlrc_pkg::ST_FULL;
                  end else if (out_of_order) begin
                     status_in = tlrc_pkg::ST_ORDER;
                  end else begin
                     last_stamp_in  = req_chan.order_time;
                     last_prefix_in = new_prefix;
                     entry_count_in = entry_count_ff + CNT_W'(1);
                  end
               end else if (!log_empty && (req_chan.start_time <= req_chan.end_time)) begin
                  key_l_in = req_chan.start_time;
                  key_r_in = req_chan.end_time;
                  hi_l_in  = entry_count_ff;
                  hi_r_in  = entry_count_ff;
                  sel_in   = 1'b0;
                  pend_in  = 1'b0;
                  state_in = S_SEARCH;
               end
            end
         end

         S_SEARCH: begin
            // retire the probe issued last cycle
            if (pend_ff) begin
               if (sel_ff) begin
                  if (hit) lo_l_in = mid_ff + CNT_W'(1);
                  else     hi_l_in = mid_ff;
               end else begin
                  if (hit) lo_r_in = mid_ff + CNT_W'(1);
                  else     hi_r_in = mid_ff;
               end
            end
            // issue this search's probe
            pend_in = sel_active;
            mid_in  = mid_cur;
            sel_in  = !sel_ff;
            if (!(lo_l_in < hi_l_in) && !(lo_r_in < hi_r_in)) begin
               pend_in  = 1'b0;
               state_in = S_FETCH_R;
            end
         end

         S_FETCH_R: begin
            state_in = S_FETCH_L;
         end

         S_FETCH_L: begin
            p_r_in   = (lo_r_ff == '0) ? '0 : rd_prefix;
            state_in = S_LATCH_L;
         end

         S_LATCH_L: begin
            p_l_in   = (lo_l_ff == '0) ? '0 : rd_prefix;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_status_in = status_ff;
               rsp_count_in  = tlrc_pkg::WCOUNT_W'(win_count);
               rsp_sum_in    = win_sum;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         sel_ff         <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         sel_ff         <= sel_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      last_stamp_ff  <= last_stamp_in;
      last_prefix_ff <= last_prefix_in;
      key_l_ff       <= key_l_in;
      key_r_ff       <= key_r_in;
      lo_l_ff        <= lo_l_in;
      hi_l_ff        <= hi_l_in;
      lo_r_ff        <= lo_r_in;
      hi_r_ff        <= hi_r_in;
      mid_ff         <= mid_in;
      p_r_ff         <= p_r_in;
      p_l_ff         <= p_l_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_sum_ff     <= rsp_sum_in;
   end

   // response port
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.window_count    = rsp_count_ff;
   assign rsp_chan.window_cost_sum = rsp_sum_ff;

   // checks
   `TLRC_ASSERT_ALWAYS(a_count_bound, entry_count_ff <= CNT_W'(tlrc_pkg::LOG_DEPTH), "log count above depth")
   `TLRC_ASSERT_NEXT(a_accept_leaves_idle, req_chan.valid && req_chan.ready, state_ff != S_IDLE, "accepted item left sequencer idle")
   `TLRC_ASSERT_IMPLY(a_search_bounds, state_ff == S_SEARCH, (lo_l_ff <= hi_l_ff) && (lo_r_ff <= hi_r_ff), "search bounds crossed")
   `TLRC_ASSERT_IMPLY(a_window_order, state_ff == S_DONE, lo_l_ff <= lo_r_ff, "window start beyond window end")

endmodule

/* sim/tb.sv */
// Testbench of the timestamped log range unit: directed and random traffic against a predictor
`timescale 1ns / 1ps

module tb;

   localparam int TIME_W    = tlrc_pkg::TIME_W;
   localparam int COST_W    = tlrc_pkg::COST_W;
   localparam int SUM_W     = tlrc_pkg::SUM_W;
   localparam int STATUS_W  = tlrc_pkg::STATUS_W;
   localparam int WCOUNT_W  = tlrc_pkg::WCOUNT_W;
   localparam int LOG_DEPTH = tlrc_pkg::LOG_DEPTH;
   localparam logic [STATUS_W-1:0] ST_OK    = tlrc_pkg::ST_OK;
   localparam logic [STATUS_W-1:0] ST_FULL  = tlrc_pkg::ST_FULL;
   localparam logic [STATUS_W-1:0] ST_ORDER = tlrc_pkg::ST_ORDER;
   localparam logic CMD_APPEND = tlrc_pkg::CMD_APPEND;
   localparam logic CMD_QUERY  = tlrc_pkg::CMD_QUERY;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 60;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [COST_W-1:0] COST_MAX = '1;

   typedef struct packed {
      logic              command;
      logic [TIME_W-1:0] order_time;
      logic [COST_W-1:0] order_cost;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
   } order_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WCOUNT_W-1:0] window_count;
      logic [SUM_W-1:0]    window_cost_sum;
   } window_result_type;

   logic clock = 1'b0;
   logic reset;

   tlrc_req_if req_chan ();
   tlrc_rsp_if rsp_chan ();

   timestamped_log_range_count_sum_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor's own copy of the log
   logic [TIME_W-1:0] stamp_log [LOG_DEPTH];
   logic [SUM_W-1:0]  running_sum_log [LOG_DEPTH];
   int                logged;

   window_result_type awaited_results [$];
   window_result_type oldest;
   int                mismatch_count;
   int                quiet_cycles = 0;
   int                send_idle_pct;
   int                recv_stall_pct;

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // last entry with a stamp at or below t, -1 if none
   function automatic int last_stamp_upto(input logic [TIME_W-1:0] t);
      int lo;
      int hi;
      int mid;
      int found;
      lo    = 0;
      hi    = logged - 1;
      found = -1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (stamp_log[mid] <= t) begin
            found = mid;
            lo    = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return found;
   endfunction

   // updates the log copy and returns the result the item should produce
   function automatic window_result_type predict_window(input order_item_type item);
      window_result_type res;
      logic [SUM_W-1:0]  base;
      int                lo_idx;
      int                hi_idx;
      res        = '0;
      res.status = ST_OK;
      if (item.command == CMD_APPEND) begin
         // full check takes precedence over the ordering check
         if (logged >= LOG_DEPTH) begin
            res.status = ST_FULL;
         end else if (logged > 0 && item.order_time < stamp_log[logged-1]) begin
            res.status = ST_ORDER;
         end else begin
            base = (logged > 0) ? running_sum_log[logged-1] : '0;
            stamp_log[logged]       = item.order_time;
            running_sum_log[logged] = base + item.order_cost;
            logged++;
         end
      end else if (logged > 0 && item.start_time <= item.end_time) begin
         lo_idx = last_stamp_upto(item.start_time);
         hi_idx = last_stamp_upto(item.end_time);
         if (hi_idx >= 0) begin
            if (lo_idx >= 0) begin
               res.window_count    = WCOUNT_W'(hi_idx - lo_idx);
               res.window_cost_sum = running_sum_log[hi_idx] - running_sum_log[lo_idx];
            end else begin
               // nothing at or before the start: window opens at the first entry
               res.window_count    = WCOUNT_W'(hi_idx + 1);
               res.window_cost_sum = running_sum_log[hi_idx];
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic [TIME_W-1:0] any_word64();
      return {$urandom, $urandom};
   endfunction

   function automatic order_item_type order_item(input logic              cmd,
                                                 input logic [TIME_W-1:0] otime,
                                                 input logic [COST_W-1:0] cost,
                                                 input logic [TIME_W-1:0] st,
                                                 input logic [TIME_W-1:0] et);
      order_item_type item;
      item.command    = cmd;
      item.order_time = otime;
      item.order_cost = cost;
      item.start_time = st;
      item.end_time   = et;
      return item;
   endfunction

   // step to the next stamp: often equal, mostly small, now and then a big jump
   function automatic logic [TIME_W-1:0] next_gap(input logic [TIME_W-1:0] newest);
      logic [TIME_W-1:0] gap;
      case ($urandom_range(0, 9))
         0, 1, 2: gap = '0;
         9:       gap = any_word64() >> $urandom_range(8, 63);
         default: gap = TIME_W'($urandom_range(1, 40));
      endcase
      if (gap > ~newest)
         gap = '0;
      return gap;
   endfunction

   // a time on, just below or just above a logged stamp
   function automatic logic [TIME_W-1:0] probe_time();
      logic [TIME_W-1:0] t;
      if (logged == 0)
         return any_word64();
      t = stamp_log[$urandom_range(0, logged - 1)];
      case ($urandom_range(0, 2))
         0:       t = t - 1'b1;
         2:       t = t + 1'b1;
         default: ;
      endcase
      return t;
   endfunction

   function automatic order_item_type random_order(input int query_pct, input int disorder_pct);
      order_item_type    item;
      logic [TIME_W-1:0] newest;
      logic [TIME_W-1:0] swap;
      item.command    = ($urandom_range(0, 99) < query_pct) ? CMD_QUERY : CMD_APPEND;
      item.order_time = any_word64();
      item.order_cost = $urandom;
      item.start_time = any_word64();
      item.end_time   = any_word64();
      newest = (logged > 0) ? stamp_log[logged-1] : '0;
      if (item.command == CMD_APPEND) begin
         // a full log refuses any time, so the random one stays there
         if (logged < LOG_DEPTH) begin
            if (newest != 0 && $urandom_range(0, 99) < disorder_pct)
               item.order_time = any_word64() % newest;
            else
               item.order_time = newest + next_gap(newest);
         end
      end else begin
         if ($urandom_range(0, 4) != 0) begin
            item.start_time = probe_time();
            item.end_time   = probe_time();
         end
         // mostly proper windows, a few empty or reversed ones
         if ($urandom_range(0, 19) == 0) begin
            item.end_time = item.start_time;
         end else if (item.start_time > item.end_time && $urandom_range(0, 7) != 0) begin
            swap            = item.start_time;
            item.start_time = item.end_time;
            item.end_time   = swap;
         end
      end
      return item;
   endfunction

   // ---------------------------------------------------------------- driving

   // offers one item, waits for it to be taken and records its expected result
   task automatic send_item(input order_item_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.command    = item.command;
      req_chan.order_time = item.order_time;
      req_chan.order_cost = item.order_cost;
      req_chan.start_time = item.start_time;
      req_chan.end_time   = item.end_time;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      awaited_results.insert(awaited_results.size(), predict_window(item));
      @(negedge clock);
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic wait_for_results();
      req_chan.valid = 1'b0;
      while (awaited_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // receiver stalls at random
   always @(negedge clock)
      rsp_chan.ready = ($urandom_range(0, 99) >= recv_stall_pct);

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_results.size() == 0) begin
            $error("result with no item outstanding: status %0d count %0d sum %0d",
                   rsp_chan.status, rsp_chan.window_count, rsp_chan.window_cost_sum);
            mismatch_count++;
         end else begin
            oldest = awaited_results.pop_front();
            if (rsp_chan.status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_chan.status);
               mismatch_count++;
            end
            if (rsp_chan.window_count !== oldest.window_count) begin
               $error("window_count: expected %0d, got %0d",
                      oldest.window_count, rsp_chan.window_count);
               mismatch_count++;
            end
            if (rsp_chan.window_cost_sum !== oldest.window_cost_sum) begin
               $error("window_cost_sum: expected %0d, got %0d",
                      oldest.window_cost_sum, rsp_chan.window_cost_sum);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // queries on an empty log answer zero
   task automatic test_empty_log();
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, '0, TIME_MAX));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, TIME_MAX, '0));
   endtask

   // first appends: extreme costs, equal stamp, out-of-order refusals
   task automatic test_first_orders();
      send_item(order_item(CMD_APPEND, 64'd100, COST_MAX, any_word64(), any_word64()));
      send_item(order_item(CMD_APPEND, 64'd100, '0, any_word64(), any_word64()));
      send_item(order_item(CMD_APPEND, '0, 32'd5, any_word64(), any_word64()));
      send_item(order_item(CMD_APPEND, 64'd99, 32'd9, any_word64(), any_word64()));
      send_item(order_item(CMD_APPEND, 64'd250, 32'd7, any_word64(), any_word64()));
      send_item(order_item(CMD_APPEND, 64'd250, 32'd1, any_word64(), any_word64()));
      send_item(order_item(CMD_APPEND, 64'd1000, 32'h8000_0000, any_word64(), any_word64()));
   endtask

   // window edge cases over the small log built above
   task automatic test_window_cases();
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, '0, TIME_MAX));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, '0, 64'd99));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, 64'd100, 64'd250));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, 64'd250, 64'd250));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, 64'd251, 64'd100));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, TIME_MAX, TIME_MAX));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, 64'd99, 64'd100));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, 64'd999, 64'd1000));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, '0, '0));
      wait_for_results();
   endtask

   // mixed appends and queries under one idling pattern, then a full drain
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (PHASE_ITEMS)
         send_item(random_order(35, 10));
      wait_for_results();
   endtask

   // fill the log, top it with the largest stamp, then exercise the full log
   task automatic test_log_full();
      logic [TIME_W-1:0] newest;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (logged < LOG_DEPTH - 1) begin
         newest = stamp_log[logged-1];
         send_item(order_item(CMD_APPEND, newest + next_gap(newest), $urandom,
                              any_word64(), any_word64()));
      end
      send_item(order_item(CMD_APPEND, TIME_MAX, COST_MAX, any_word64(), any_word64()));
      send_item(order_item(CMD_APPEND, TIME_MAX, $urandom, any_word64(), any_word64()));
      // full refusal wins over the ordering check
      send_item(order_item(CMD_APPEND, '0, $urandom, any_word64(), any_word64()));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, '0, TIME_MAX));
      send_item(order_item(CMD_QUERY, any_word64(), $urandom, TIME_MAX, TIME_MAX));
      send_idle_pct  = 9;
      recv_stall_pct = 9;
      repeat (100)
         send_item(random_order(50, 10));
      wait_for_results();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_APPEND;
      req_chan.order_time = '0;
      req_chan.order_cost = '0;
      req_chan.start_time = '0;
      req_chan.end_time   = '0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      logged              = 0;
      mismatch_count      = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_log();
      test_first_orders();
      test_window_cases();
      test_random_traffic(0, 0);
      test_random_traffic(71, 0);
      test_random_traffic(0, 71);
      test_random_traffic(9, 9);
      test_log_full();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
